### rtl/swrtk_pkg.sv
// Shared types and constants for the LIFO stack with reverse-top-K.
// No dependencies.
package swrtk_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;
    localparam int CMP_W   = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
    localparam int WORD_W  = 32;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_DUMP = 2'd2,
        ACT_REV  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_SHORT     = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [WORD_W-1:0] value;
        logic [COUNT_W-1:0]       count;
    } cmd_beat_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [WORD_W-1:0] data;
        logic                     last;
    } rsp_beat_t;

endpackage

### rtl/swrtk_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module swrtk_ram #(
    parameter int WIDTH   = 32,
    parameter int DEPTH_P = 16
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH_P)-1:0] wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH_P)-1:0] rd_addr,
    output logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/stack_with_reverse_top_k_unit.sv
// Flow: push and every single-beat status result go through S_EMIT, pop through its RAM read and
// S_POP, before loading the output register; dump reads its first word, then loads one beat per
// cycle while the output is not stalled; reverse of K >= 2 runs S_REV_RD_LO, then a pass of
// S_REV_RD_HI, S_REV_WR_LO and S_REV_WR_HI for each of floor(K/2) swaps, then S_EMIT.
// Commands are taken one at a time, the next the cycle after the last beat loads.
// Reset clears fill count and control; stack contents stay undefined until written.
module stack_with_reverse_top_k_unit
    import swrtk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_EMIT      = 8'b0000_0010,
        S_POP       = 8'b0000_0100,
        S_DUMP      = 8'b0000_1000,
        S_REV_RD_LO = 8'b0001_0000,
        S_REV_RD_HI = 8'b0010_0000,
        S_REV_WR_LO = 8'b0100_0000,
        S_REV_WR_HI = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [ADDR_W-1:0]   lo_reg, lo_next;
    logic [ADDR_W-1:0]   hi_reg, hi_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [WORD_W-1:0]   tmp_reg, tmp_next;
    status_t             res_status_reg, res_status_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_beat_t           rsp_reg, rsp_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   rd_data;

    logic                emit;
    rsp_beat_t           emit_beat;
    logic                slot_free;
    logic                full;
    logic                empty;
    logic [CMP_W-1:0]    fill_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic                dump_last;
    logic                rev_more;

    swrtk_ram #(
        .WIDTH   (WORD_W),
        .DEPTH_P (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign empty     = (fill_reg == '0);
    assign fill_ext  = CMP_W'(fill_reg);
    assign cnt_ext   = CMP_W'(cmd.count);
    assign dump_last = ((FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg);
    assign rev_more  = (({1'b0, lo_reg} + (ADDR_W + 1)'(2)) < {1'b0, hi_reg});

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        tmp_next        = tmp_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = lo_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = lo_reg;
        emit            = 1'b0;
        emit_beat       = '{status: ST_OK, data: '0, last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.action)
                        ACT_PUSH:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = fill_reg[ADDR_W-1:0];
                                wr_data         = cmd.value;
                                fill_next       = fill_reg + FILL_W'(1);
                                res_status_next = ST_OK;
                            end
                            state_next = S_EMIT;
                        end
                        ACT_POP:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_UNDERFLOW;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = ADDR_W'(fill_reg - FILL_W'(1));
                                fill_next  = fill_reg - FILL_W'(1);
                                state_next = S_POP;
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        ACT_REV:
                        begin
                            if (cnt_ext > fill_ext)
                            begin
                                res_status_next = ST_SHORT;
                                state_next      = S_EMIT;
                            end
                            else if (cnt_ext < CMP_W'(2))
                            begin
                                res_status_next = ST_OK;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                lo_next    = ADDR_W'(fill_ext - cnt_ext);
                                hi_next    = ADDR_W'(fill_reg - FILL_W'(1));
                                state_next = S_REV_RD_LO;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    emit             = 1'b1;
                    emit_beat.status = res_status_reg;
                    state_next       = S_IDLE;
                end
            end
            S_POP:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    emit_beat.data = rd_data;
                    state_next     = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    emit_beat.data = rd_data;
                    emit_beat.last = dump_last;
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                    end
                end
            end
            S_REV_RD_LO:
            begin
                rd_en      = 1'b1;
                rd_addr    = lo_reg;
                state_next = S_REV_RD_HI;
            end
            S_REV_RD_HI:
            begin
                rd_en      = 1'b1;
                rd_addr    = hi_reg;
                tmp_next   = rd_data;
                state_next = S_REV_WR_LO;
            end
            S_REV_WR_LO:
            begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg;
                wr_data    = rd_data;
                state_next = S_REV_WR_HI;
            end
            S_REV_WR_HI:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = tmp_reg;
                if (rev_more)
                begin
                    lo_next    = lo_reg + ADDR_W'(1);
                    hi_next    = hi_reg - ADDR_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = lo_reg + ADDR_W'(1);
                    state_next = S_REV_RD_HI;
                end
                else
                begin
                    res_status_next = ST_OK;
                    state_next      = S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit_beat;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
            rsp_next       = rsp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        idx_reg        <= idx_next;
        tmp_reg        <= tmp_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DEPTH))
        else $error("fill count above depth");

    a_not_last_is_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.last) |-> (rsp.status == ST_OK))
        else $error("non-final beat with error status");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && cmd.action == ACT_PUSH && !full)
        |=> (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("push did not grow the stack");

    a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REV_RD_LO || state_reg == S_REV_RD_HI
         || state_reg == S_REV_WR_LO || state_reg == S_REV_WR_HI)
        |-> (lo_reg < hi_reg))
        else $error("swap pointers crossed");
`endif

endmodule
